>>> rtl/ctat_pkg.sv
`default_nettype none

package ctat_pkg;

  // lexer modes
  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_SLASH   = 3'd1;
  localparam logic [2:0] MODE_COMMENT = 3'd2;
  localparam logic [2:0] MODE_QUOTE   = 3'd3;

  // result kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_PUNCT = 2'd2;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_char;
  } res_t;

  // everything one input item produces
  typedef struct packed {
    logic [2:0] mode_next;
    logic       open_next;
    logic [1:0] count;
    res_t [MAX_RES-1:0] res;
  } step_t;

endpackage

`default_nettype wire

>>> rtl/ctat_decode.sv
`default_nettype none

module ctat_decode (
  input  wire logic [2:0]     mode,
  input  wire logic           token_open,
  input  wire logic [7:0]     text_byte,
  input  wire logic           end_of_text,
  output ctat_pkg::step_t     step
);
  import ctat_pkg::*;

  logic [1:0] n;
  logic       do_normal;

  always_comb begin
    n         = 2'd0;
    do_normal = 1'b0;
    step      = '0;
    step.mode_next = mode;
    step.open_next = token_open;

    if (end_of_text) begin
      if (mode == MODE_SLASH) begin
        step.res[n] = '{kind: KIND_CHAR, token_char: CH_SLASH};
        n = n + 2'd1;
        step.open_next = 1'b1;
      end
      if (step.open_next) begin
        step.res[n] = '{kind: KIND_END, token_char: 8'h00};
        n = n + 2'd1;
      end
      step.mode_next = MODE_NORMAL;
      step.open_next = 1'b0;
    end else begin
      case (mode)
        MODE_SLASH: begin
          if (text_byte == CH_SLASH) begin
            if (step.open_next) begin
              step.res[n] = '{kind: KIND_END, token_char: 8'h00};
              n = n + 2'd1;
              step.open_next = 1'b0;
            end
            step.mode_next = MODE_COMMENT;
          end else begin
            step.res[n] = '{kind: KIND_CHAR, token_char: CH_SLASH};
            n = n + 2'd1;
            step.open_next = 1'b1;
            step.mode_next = MODE_NORMAL;
            do_normal = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (text_byte == CH_NEWLINE) step.mode_next = MODE_NORMAL;
        end
        MODE_QUOTE: begin
          if (text_byte == CH_QUOTE) begin
            if (step.open_next) begin
              step.res[n] = '{kind: KIND_END, token_char: 8'h00};
              n = n + 2'd1;
              step.open_next = 1'b0;
            end
            step.mode_next = MODE_NORMAL;
          end else begin
            step.res[n] = '{kind: KIND_CHAR, token_char: text_byte};
            n = n + 2'd1;
            step.open_next = 1'b1;
          end
        end
        default: begin
          step.mode_next = MODE_NORMAL;
          do_normal = 1'b1;
        end
      endcase

      if (do_normal) begin
        if (text_byte == CH_SLASH) begin
          step.mode_next = MODE_SLASH;
        end else if (text_byte == CH_HASH || text_byte == CH_QUOTE ||
                     text_byte inside {[8'd9:8'd13], 8'd32} ||
                     text_byte inside {CH_LBRACE, CH_RBRACE, CH_EQUALS,
                                       CH_LPAREN, CH_RPAREN, CH_COMMA}) begin
          // all of these close an open token first
          if (step.open_next) begin
            step.res[n] = '{kind: KIND_END, token_char: 8'h00};
            n = n + 2'd1;
            step.open_next = 1'b0;
          end
          if (text_byte == CH_HASH) begin
            step.mode_next = MODE_COMMENT;
          end else if (text_byte == CH_QUOTE) begin
            step.mode_next = MODE_QUOTE;
          end else if (text_byte inside {CH_LBRACE, CH_RBRACE, CH_EQUALS,
                                         CH_LPAREN, CH_RPAREN, CH_COMMA}) begin
            step.res[n] = '{kind: KIND_PUNCT, token_char: text_byte};
            n = n + 2'd1;
          end
        end else begin
          step.res[n] = '{kind: KIND_CHAR, token_char: text_byte};
          n = n + 2'd1;
          step.open_next = 1'b1;
        end
      end
    end

    step.count = n;
  end

endmodule

`default_nettype wire

>>> rtl/ctat_burst.sv
`default_nettype none

module ctat_burst (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire ctat_pkg::step_t      step,
  output logic                      load_ok,
  output logic                      m_valid,
  input  wire logic                 m_ready,
  output ctat_pkg::res_t            m_res,
  output logic                      m_last
);
  import ctat_pkg::*;

  res_t [MAX_RES-1:0] res;
  logic [1:0]         pos;
  logic [1:0]         rem;

  assign m_valid = (rem != 2'd0);
  assign m_last  = (rem == 2'd1);
  assign m_res   = res[pos];
  // free now, or the final result leaves this cycle
  assign load_ok = (rem == 2'd0) || (rem == 2'd1 && m_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      pos <= 2'd0;
    end else if (load) begin
      rem <= step.count;
      pos <= 2'd0;
    end else if (m_valid && m_ready) begin
      rem <= rem - 2'd1;
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= step.res;
    end
  end

endmodule

`default_nettype wire

>>> rtl/comment_aware_text_tokenizer.sv
`default_nettype none

// Channel  | Dir | Signals                          | Payload
// s_axis   | in  | tvalid tready tdata[7:0] tuser   | tdata: text_byte; tuser: end_of_text
// m_axis   | out | tvalid tready tdata[7:0] tuser   | tdata: token_char; tuser: kind;
//          |     | tlast                            | tlast: last_of_run
//
// One byte is taken per cycle while s_axis_tready is high. Each item is decoded in
// the cycle it is accepted and its 0..3 results land in the result register together.
// An item with one result or none sustains one item per cycle while the output is ready;
// an item with n > 1 results holds the input while all but the last of them drain.
// Reset (rst, synchronous) returns the lexer to normal mode with no open
// token and drops any undelivered results.
// Output stalls back up into tready only once the last buffered result waits.

module comment_aware_text_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  wire logic       s_axis_tuser,   // [0] end_of_text
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] token_char
  output logic [1:0]      m_axis_tuser,   // [1:0] kind
  output logic            m_axis_tlast    // last_of_run
);
  import ctat_pkg::*;

  // lexer state
  logic [2:0] mode;
  logic       token_open;

  step_t step;
  res_t  out_res;
  logic  accept;
  logic  load_ok;

  assign s_axis_tready = load_ok;
  assign accept        = s_axis_tvalid && load_ok;

  ctat_decode u_decode (
    .mode        (mode),
    .token_open  (token_open),
    .text_byte   (s_axis_tdata),
    .end_of_text (s_axis_tuser),
    .step        (step)
  );

  // mode and open-token flag advance on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      token_open <= 1'b0;
    end else if (accept) begin
      mode       <= step.mode_next;
      token_open <= step.open_next;
    end
  end

  // result register + serialiser for multi-result items
  ctat_burst u_burst (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .step    (step),
    .load_ok (load_ok),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_res   (out_res),
    .m_last  (m_axis_tlast)
  );

  assign m_axis_tdata = out_res.token_char;
  assign m_axis_tuser = out_res.kind;

endmodule

`default_nettype wire

>>> rtl/ctat_checker.sv
`default_nettype none

module ctat_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tready,
  input  wire logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  input  wire logic [7:0] m_axis_tdata,
  input  wire logic [1:0] m_axis_tuser,
  input  wire logic       m_axis_tlast
);
  import ctat_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // input only stalls while results are pending
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // reset leaves no result behind
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

  // end markers carry no character and kind code 3 never appears
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == KIND_CHAR || m_axis_tuser == KIND_PUNCT ||
                       (m_axis_tuser == KIND_END && m_axis_tdata == 8'h00)))
    else $error("bad result kind or end marker character");

  // a punctuation result always closes the run of its item
  a_punct_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_PUNCT |-> m_axis_tlast)
    else $error("punctuation result not last of its run");

endmodule

bind comment_aware_text_tokenizer ctat_checker u_ctat_checker (.*);

`default_nettype wire
